FILE: hw/rtl/annexb_nalu_splitter_top_macros.svh
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter assertion macros
// Shared concurrent assertion wrappers; they are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ANNEXB_NALU_SPLITTER_TOP_MACROS_SVH
`define ANNEXB_NALU_SPLITTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SPLIT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define SPLIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define SPLIT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPLIT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/annb_split_pkg.sv
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter package
// Constants and shared types of the splitter's scan and output stages.
// ----------------------------------------------------------------------------
`default_nettype none

package annb_split_pkg;

   localparam int MaxResults = 5;
   localparam int HoldDepth  = 4;
   localparam int CountWidth = 3;

   localparam logic [7:0] ZeroByte    = 8'h00;
   localparam logic [7:0] StartLast   = 8'h01;
   localparam logic [7:0] NalTypeMask = 8'h1F;
   localparam logic [7:0] NalTypeIdr  = 8'h05;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       unit_first;
      logic       unit_last;
      logic       key_unit;
      logic       empty_unit;
   } result_type;

   typedef result_type [MaxResults-1:0] result_vec_type;

   // All results that one stream byte produces, in order, with their count.
   typedef struct packed {
      result_vec_type          slot;
      logic [CountWidth-1:0]   count;
   } step_type;

endpackage

`default_nettype wire

FILE: hw/rtl/annb_split_scan.sv
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter scan stage
// Start code detection, byte hold-back and unit state for one byte per cycle while step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "annexb_nalu_splitter_top_macros.svh"

module annb_split_scan (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic [7:0]               byte_in,
   input  wire logic                     chunk_end,
   output annb_split_pkg::step_type      step_out
);

   localparam int CW = annb_split_pkg::CountWidth;

   logic [annb_split_pkg::HoldDepth-1:0][7:0] hold_ff, hold_in;
   logic [CW-1:0] hold_count_ff, hold_count_in;
   logic          inside_ff, inside_in;
   logic          none_ff, none_in;
   logic          key_ff, key_in;

   logic [annb_split_pkg::MaxResults-1:0][7:0] win;
   logic          zb1, zb2, zb3, t0, t1, t2, start, last_flag, key_now;
   logic          pre_empty, post_empty;
   logic [CW-1:0] n, z, keep, m, bcnt;

   function automatic logic [7:0] pick(
      input logic [annb_split_pkg::MaxResults-1:0][7:0] w,
      input logic [CW-1:0] idx
   );
      logic [7:0] r;
      r = annb_split_pkg::ZeroByte;
      if (idx < CW'(annb_split_pkg::MaxResults)) begin
         r = w[idx];
      end
      return r;
   endfunction

   // The window is the held bytes followed by the new byte.
   always_comb begin
      for (int i = 0; i < annb_split_pkg::HoldDepth; i++) begin
         if (CW'(i) < hold_count_ff) begin
            win[i] = hold_ff[i];
         end else if (CW'(i) == hold_count_ff) begin
            win[i] = byte_in;
         end else begin
            win[i] = annb_split_pkg::ZeroByte;
         end
      end
      win[annb_split_pkg::HoldDepth] = (hold_count_ff == CW'(annb_split_pkg::HoldDepth)) ?
                                       byte_in : annb_split_pkg::ZeroByte;
   end

   always_comb begin
      zb1 = (hold_count_ff >= CW'(1)) &&
            (pick(win, hold_count_ff - CW'(1)) == annb_split_pkg::ZeroByte);
      zb2 = (hold_count_ff >= CW'(2)) &&
            (pick(win, hold_count_ff - CW'(2)) == annb_split_pkg::ZeroByte);
      zb3 = (hold_count_ff >= CW'(3)) &&
            (pick(win, hold_count_ff - CW'(3)) == annb_split_pkg::ZeroByte);
      start = (byte_in == annb_split_pkg::StartLast) && zb1 && zb2 && zb3;

      // Trailing zeros might open a start code, so they and one byte before
      // them are held back.
      t0   = (byte_in == annb_split_pkg::ZeroByte);
      t1   = t0 && zb1;
      t2   = t1 && zb2;
      z    = CW'(t0) + CW'(t1) + CW'(t2);
      n    = hold_count_ff + CW'(1);
      keep = (n > z) ? z + CW'(1) : z;

      // Emitted bytes are always a prefix of the window.
      if (start) begin
         m = (hold_count_ff == CW'(annb_split_pkg::HoldDepth)) ? CW'(1) : CW'(0);
      end else if (chunk_end) begin
         m = n;
      end else begin
         m = n - keep;
      end
      bcnt       = inside_ff ? m : CW'(0);
      pre_empty  = start && (hold_count_ff != CW'(annb_split_pkg::HoldDepth)) &&
                   inside_ff && none_ff;
      post_empty = start && chunk_end;
      last_flag  = start || chunk_end;
      key_now    = none_ff ? ((win[0] & annb_split_pkg::NalTypeMask) ==
                              annb_split_pkg::NalTypeIdr) : key_ff;

      step_out.count = bcnt + CW'(pre_empty) + CW'(post_empty);
      for (int i = 0; i < annb_split_pkg::MaxResults; i++) begin
         if (CW'(i) < bcnt) begin
            step_out.slot[i].payload_byte = win[i];
            step_out.slot[i].unit_first   = (i == 0) && none_ff;
            step_out.slot[i].unit_last    = last_flag && (CW'(i) == bcnt - CW'(1));
            step_out.slot[i].key_unit     = key_now;
            step_out.slot[i].empty_unit   = 1'b0;
         end else begin
            step_out.slot[i].payload_byte = annb_split_pkg::ZeroByte;
            step_out.slot[i].unit_first   = 1'b1;
            step_out.slot[i].unit_last    = 1'b1;
            step_out.slot[i].key_unit     = 1'b0;
            step_out.slot[i].empty_unit   = 1'b1;
         end
      end
   end

   always_comb begin
      hold_count_in = hold_count_ff;
      inside_in     = inside_ff;
      none_in       = none_ff;
      key_in        = key_ff;
      for (int j = 0; j < annb_split_pkg::HoldDepth; j++) begin
         hold_in[j] = pick(win, m + CW'(j));
      end
      if (step_en) begin
         if (chunk_end) begin
            hold_count_in = '0;
            inside_in     = 1'b0;
            none_in       = 1'b1;
            key_in        = 1'b0;
         end else if (start) begin
            hold_count_in = '0;
            inside_in     = 1'b1;
            none_in       = 1'b1;
            key_in        = 1'b0;
         end else begin
            hold_count_in = keep;
            if (bcnt != CW'(0)) begin
               none_in = 1'b0;
               key_in  = key_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= '0;
         inside_ff     <= 1'b0;
         none_ff       <= 1'b1;
         key_ff        <= 1'b0;
      end else begin
         hold_count_ff <= hold_count_in;
         inside_ff     <= inside_in;
         none_ff       <= none_in;
         key_ff        <= key_in;
      end
   end

   `SPLIT_ASSERT_IMP(a_hold_bound, clock, reset, 1'b1,
                     hold_count_ff <= CW'(annb_split_pkg::HoldDepth))
   `SPLIT_ASSERT_NEXT(a_chunk_flush, clock, reset, step_en && chunk_end,
                      !inside_ff && none_ff && (hold_count_ff == CW'(0)))

endmodule

`default_nettype wire

FILE: hw/rtl/annb_split_outq.sv
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter result buffer
// Holds the results of one byte and hands them out one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "annexb_nalu_splitter_top_macros.svh"

module annb_split_outq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire annb_split_pkg::step_type   step_in,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output annb_split_pkg::result_type      rsp_data,
   output logic                            free
);

   localparam int CW = annb_split_pkg::CountWidth;

   annb_split_pkg::result_vec_type slots_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;

   always_comb begin
      rsp_valid = (idx_ff != count_ff);
      rsp_data  = slots_ff[0];
      if (idx_ff < CW'(annb_split_pkg::MaxResults)) begin
         rsp_data = slots_ff[idx_ff];
      end
      // Free when drained, or when the last result leaves in this cycle.
      free = (idx_ff == count_ff) || ((idx_ff + CW'(1) == count_ff) && rsp_ready);

      count_in = count_ff;
      idx_in   = idx_ff;
      if (load) begin
         count_in = step_in.count;
         idx_in   = '0;
      end else if (rsp_valid && rsp_ready) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= step_in.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   `SPLIT_ASSERT_IMP(a_idx_bound, clock, reset, 1'b1,
                     (idx_ff <= count_ff) && (count_ff <= CW'(annb_split_pkg::MaxResults)))
   `SPLIT_ASSERT_NEXT(a_drain_continues, clock, reset,
                      rsp_valid && rsp_ready && (idx_ff + CW'(1) != count_ff) && !load,
                      rsp_valid)

endmodule

`default_nettype wire

FILE: hw/rtl/annexb_nalu_splitter_top.sv
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Splits a byte stream at 00 00 00 01 start codes into marked NAL unit bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_) carries one stream byte per request, with
//   req_chunk_end set on the final byte of a buffer. The response channel
//   (rsp_) carries one NAL unit payload byte, or one empty-unit marker, per
//   transfer, flagged first, last and key (IDR type in the first byte).
//   Bytes before the first start code of a chunk produce no response.
//   A request is captured in an input register and scanned once the result
//   buffer is free; its responses are loaded into a five-entry result
//   buffer and then appear on the rsp_ outputs. Bytes that might open a
//   start code are held back and leave with a later request. Throughput is
//   one request per cycle while each byte yields at most one response and
//   the receiver is ready; a byte that releases several responses (held
//   bytes let go at once, or a start code that closes an empty unit and
//   ends its chunk) occupies the result buffer until all of its responses
//   have left, which then paces the input.
//   When the receiver stalls, the buffer holds its results and the input
//   register holds one more request before req_ready drops.
//   Synchronous reset empties both stages and returns the scanner to
//   "outside any unit" with no bytes held.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nalu_splitter_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       req_chunk_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_unit_first,
   output logic            rsp_unit_last,
   output logic            rsp_key_unit,
   output logic            rsp_empty_unit
);

   // Input register for one request.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   logic                        free;
   logic                        step;
   annb_split_pkg::step_type    step_res;
   annb_split_pkg::result_type  rsp_data;

   // The held request is scanned once the result buffer can take its results.
   assign step      = in_valid_ff && free;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_in;
         in_end_ff  <= req_chunk_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   annb_split_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .byte_in   (in_byte_ff),
      .chunk_end (in_end_ff),
      .step_out  (step_res)
   );

   annb_split_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .step_in   (step_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (free)
   );

   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_unit_first   = rsp_data.unit_first;
   assign rsp_unit_last    = rsp_data.unit_last;
   assign rsp_key_unit     = rsp_data.key_unit;
   assign rsp_empty_unit   = rsp_data.empty_unit;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter testbench
// Sends byte-stream requests with start codes, payload and chunk ends, predicts
// the marked NAL unit bytes in step with the driver and checks every response.
// ----------------------------------------------------------------------------

module tb;

   // One stream byte as it is offered on the request channel.
   typedef struct packed {
      logic [7:0] data;
      logic       chunk_end;
   } stream_item_type;

   localparam int StallBurstCycles = 150;
   localparam int WatchdogLimit    = 3000;
   localparam int MaxReported      = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte_in = 8'h00;
   logic       req_chunk_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_unit_first;
   logic       rsp_unit_last;
   logic       rsp_key_unit;
   logic       rsp_empty_unit;

   // Requests waiting to be driven, and the responses that accepted requests
   // have already caused but that have not come out yet.
   stream_item_type            stream_bytes_to_send[$];
   annb_split_pkg::result_type expected_nal_bytes[$];

   // Shadow copy of the splitter's scan state.
   logic [7:0] held_bytes [0:annb_split_pkg::HoldDepth-1];
   int         held_count = 0;
   logic       in_unit = 1'b0;
   logic       unit_untouched = 1'b1;
   logic       unit_is_key = 1'b0;

   int mismatches = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_left = 0;
   logic stall_arm = 1'b0;
   int quiet_cycles = 0;

   annexb_nalu_splitter_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_chunk_end    (req_chunk_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_unit_first   (rsp_unit_first),
      .rsp_unit_last    (rsp_unit_last),
      .rsp_key_unit     (rsp_key_unit),
      .rsp_empty_unit   (rsp_empty_unit)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Appends one response to the tail of the expectation queue.
   task automatic append_expected(input annb_split_pkg::result_type r);
      expected_nal_bytes.insert(expected_nal_bytes.size(), r);
   endtask

   // A payload byte of the current unit. Outside a unit the byte is simply
   // dropped. The first byte of a unit decides its key flag from its type.
   task automatic emit_nal_byte(input logic [7:0] data, input logic ends_unit);
      annb_split_pkg::result_type r;
      if (!in_unit) begin
         return;
      end
      if (unit_untouched) begin
         unit_is_key = ((data & annb_split_pkg::NalTypeMask) ==
                        annb_split_pkg::NalTypeIdr);
      end
      r.payload_byte = data;
      r.unit_first   = unit_untouched;
      r.unit_last    = ends_unit;
      r.key_unit     = unit_is_key;
      r.empty_unit   = 1'b0;
      unit_untouched = 1'b0;
      append_expected(r);
   endtask

   // A unit with no payload at all is reported as one marker.
   task automatic emit_empty_marker();
      annb_split_pkg::result_type r;
      r.payload_byte = annb_split_pkg::ZeroByte;
      r.unit_first   = 1'b1;
      r.unit_last    = 1'b1;
      r.key_unit     = 1'b0;
      r.empty_unit   = 1'b1;
      unit_untouched = 1'b0;
      append_expected(r);
   endtask

   // Advances the shadow state by one accepted stream byte. The window is the
   // held bytes followed by the new one; a start code can only sit at its end.
   task automatic split_stream_byte(input logic [7:0] data, input logic chunk_end);
      logic [7:0] win [0:annb_split_pkg::HoldDepth];
      int n;
      int zeros;
      int keep;
      n = 0;
      for (int i = 0; i < held_count; i++) begin
         win[n] = held_bytes[i];
         n++;
      end
      win[n] = data;
      n++;

      if (n >= 4 && win[n-4] == annb_split_pkg::ZeroByte &&
          win[n-3] == annb_split_pkg::ZeroByte &&
          win[n-2] == annb_split_pkg::ZeroByte &&
          win[n-1] == annb_split_pkg::StartLast) begin
         // The byte in front of the start code closes the previous unit; a
         // unit that never got a byte becomes an empty marker.
         if (n == annb_split_pkg::HoldDepth + 1) begin
            emit_nal_byte(win[0], 1'b1);
         end else if (in_unit && unit_untouched) begin
            emit_empty_marker();
         end
         in_unit        = 1'b1;
         unit_untouched = 1'b1;
         unit_is_key    = 1'b0;
         held_count     = 0;
         // A start code as the last byte of a chunk opens a unit that is
         // already over.
         if (chunk_end) begin
            emit_empty_marker();
         end
      end else if (chunk_end) begin
         for (int i = 0; i < n; i++) begin
            emit_nal_byte(win[i], i == n - 1);
         end
      end else begin
         // Trailing zeros might still start a code; they and the byte in
         // front of them stay held so the unit's last byte can be marked.
         zeros = 0;
         while (zeros < 3 && zeros < n && win[n-1-zeros] == annb_split_pkg::ZeroByte) begin
            zeros++;
         end
         keep = (n > zeros) ? zeros + 1 : zeros;
         for (int i = 0; i < n - keep; i++) begin
            emit_nal_byte(win[i], 1'b0);
         end
         for (int i = 0; i < keep; i++) begin
            held_bytes[i] = win[n-keep+i];
         end
         held_count = keep;
      end

      if (chunk_end) begin
         for (int i = 0; i < annb_split_pkg::HoldDepth; i++) begin
            held_bytes[i] = annb_split_pkg::ZeroByte;
         end
         held_count     = 0;
         in_unit        = 1'b0;
         unit_untouched = 1'b1;
         unit_is_key    = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver: takes the next queued byte whenever the channel is free,
   // idling at random, and feeds every accepted request to the predictor.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_request
      stream_item_type next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            split_stream_byte(req_byte_in, req_chunk_end);
         end
         if (!req_valid || req_ready) begin
            if (stream_bytes_to_send.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               next = stream_bytes_to_send.pop_front();
               req_valid     <= 1'b1;
               req_byte_in   <= next.data;
               req_chunk_end <= next.chunk_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: compares each response with the oldest expectation and
   // throttles rsp_ready, fully closed during a long receiver hold-off.
   // ------------------------------------------------------------------------
   task automatic check_nal_byte();
      annb_split_pkg::result_type want;
      if (expected_nal_bytes.size() == 0) begin
         mismatches++;
         if (mismatches <= MaxReported) begin
            $display("%0t: unexpected response: byte %02h first %0b last %0b key %0b empty %0b",
                     $realtime, rsp_payload_byte, rsp_unit_first, rsp_unit_last,
                     rsp_key_unit, rsp_empty_unit);
         end
      end else begin
         want = expected_nal_bytes.pop_front();
         if (want.payload_byte !== rsp_payload_byte || want.unit_first !== rsp_unit_first ||
             want.unit_last !== rsp_unit_last || want.key_unit !== rsp_key_unit ||
             want.empty_unit !== rsp_empty_unit) begin
            mismatches++;
            if (mismatches <= MaxReported) begin
               $display("%0t: expected byte %02h first %0b last %0b key %0b empty %0b",
                        $realtime, want.payload_byte, want.unit_first, want.unit_last,
                        want.key_unit, want.empty_unit);
               $display("%0t:      got byte %02h first %0b last %0b key %0b empty %0b",
                        $realtime, rsp_payload_byte, rsp_unit_first, rsp_unit_last,
                        rsp_key_unit, rsp_empty_unit);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_nal_byte();
         end
         rsp_ready <= (stall_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // The long hold-off runs in its own process so the sender keeps offering
   // requests while the receiver is closed and the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_arm) begin
         stall_left <= StallBurstCycles;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Watchdog: a run that stops moving in both directions is hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("[annexb_nalu_splitter_top] ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic add_stream_byte(input logic [7:0] data, input logic chunk_end);
      stream_item_type it;
      it.data      = data;
      it.chunk_end = chunk_end;
      stream_bytes_to_send.insert(stream_bytes_to_send.size(), it);
   endtask

   // Payload bytes lean toward zero so that partial start codes and held
   // zero runs show up often.
   function automatic logic [7:0] payload_pick();
      return ($urandom_range(3) == 0) ? annb_split_pkg::ZeroByte : 8'($urandom);
   endfunction

   task automatic add_start_code(input logic chunk_end);
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b0);
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b0);
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b0);
      add_stream_byte(annb_split_pkg::StartLast, chunk_end);
   endtask

   // Mostly well-formed units (start code, key or plain first byte, random
   // body, sometimes a chunk end) with some loose noise bytes in between.
   // Only the bytes of the well-formed units count toward the budget.
   task automatic queue_random_stream(input int budget);
      int sent;
      int len;
      logic [7:0] lead;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(3) == 0) begin
               add_stream_byte(payload_pick(), 1'b0);
            end
            if ($urandom_range(19) == 0) begin
               add_start_code(1'b1);
               sent += 4;
            end else begin
               add_start_code(1'b0);
               len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
               lead = 8'($urandom);
               if ($urandom_range(2) == 0) begin
                  lead[4:0] = annb_split_pkg::NalTypeIdr[4:0];
               end
               for (int j = 0; j < len; j++) begin
                  add_stream_byte((j == 0) ? lead : payload_pick(),
                                  (j == len - 1) && ($urandom_range(3) == 0));
               end
               sent += 4 + len;
            end
         end else begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) begin
               add_stream_byte(payload_pick(), (j == len - 1) && ($urandom_range(6) == 0));
            end
         end
      end
   endtask

   task automatic wait_requests_sent();
      while (stream_bytes_to_send.size() != 0 || req_valid) begin
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, with no idling on either side. A lone byte that ends
      // a chunk before any start code, then a byte dropped ahead of the first
      // start code.
      add_stream_byte(8'hAA, 1'b1);
      add_stream_byte(8'hFF, 1'b0);
      // An IDR unit (type bits 5 under nonzero upper bits) whose last byte
      // sits right in front of the next start code, so the block holds four
      // bytes and releases the oldest as the unit's end.
      add_start_code(1'b0);
      add_stream_byte(8'h65, 1'b0);
      add_stream_byte(8'hFF, 1'b0);
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b0);
      // Back-to-back start codes: the unit between them is empty.
      add_start_code(1'b0);
      add_start_code(1'b0);
      // A three-byte start code is only payload; the unit is not a key unit.
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b0);
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b0);
      add_stream_byte(annb_split_pkg::StartLast, 1'b0);
      add_stream_byte(8'h41, 1'b0);
      // Chunk end with held zeros flushes them all, the final one last.
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b0);
      add_stream_byte(annb_split_pkg::ZeroByte, 1'b1);
      // A start code that ends its chunk reports an empty unit.
      add_start_code(1'b1);
      wait_requests_sent();

      // Random part. First the receiver closes for a long stretch while the
      // sender never idles, so the block fills and pushes back.
      stall_arm = 1'b1;
      @(negedge clock);
      stall_arm = 1'b0;
      add_start_code(1'b0);
      for (int j = 0; j < 40; j++) begin
         add_stream_byte(8'($urandom_range(1, 255)), j == 39);
      end
      queue_random_stream(55);
      wait_requests_sent();

      send_idle_pct = 46;
      rsp_stall_pct = 0;
      queue_random_stream(93);
      wait_requests_sent();

      send_idle_pct = 0;
      rsp_stall_pct = 46;
      queue_random_stream(93);
      wait_requests_sent();

      send_idle_pct = 20;
      rsp_stall_pct = 20;
      queue_random_stream(93);
      wait_requests_sent();

      // Drain, then give the pipeline time to show any stray response.
      while (expected_nal_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (12) @(negedge clock);

      if (mismatches == 0 && expected_nal_bytes.size() == 0) begin
         $display("[annexb_nalu_splitter_top] OK");
      end else begin
         $display("[annexb_nalu_splitter_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/annb_split_pkg.sv
hw/rtl/annb_split_scan.sv
hw/rtl/annb_split_outq.sv
hw/rtl/annexb_nalu_splitter_top.sv
dv/tb.sv
